>>> hw/rtl/annexb_nal_unit_splitter_defines.svh
// Assertion macros used by the splitter checker.
`ifndef ANNEXB_NAL_UNIT_SPLITTER_DEFINES_SVH
`define ANNEXB_NAL_UNIT_SPLITTER_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define ANBS_ASSERT_IMP(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
		else $error("annexb splitter check failed");

// Next-cycle implication, disabled while reset is low.
`define ANBS_ASSERT_NXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
		else $error("annexb splitter check failed");

`endif

>>> hw/rtl/anbs_pkg.sv
package anbs_pkg;

	localparam int MAX_RES = 4;
	localparam int CNT_W   = 3;
	localparam int POS_W   = 2;
	localparam int SRC_N   = 5;
	localparam int SRC_W   = 3;

	localparam logic [7:0] ZERO_BYTE  = 8'h00;
	localparam logic [7:0] START_BYTE = 8'h01;
	localparam logic [4:0] TYPE_MASK  = 5'h1F;
	localparam logic [1:0] HOLD_SAT   = 2'd3;
	localparam logic [2:0] SEEN_SAT   = 3'd4;

	typedef struct packed {
		logic [7:0] byte_in;
		logic       buffer_end;
	} in_item_t;

	typedef struct packed {
		logic [7:0] payload_byte;
		logic       unit_first;
		logic       unit_last;
		logic [4:0] unit_type;
		logic       buffer_done;
	} out_item_t;

	// Results caused by one accepted input item.
	typedef struct packed {
		logic [CNT_W-1:0]             count;
		out_item_t [MAX_RES-1:0]      items;
	} bundle_t;

endpackage

>>> hw/rtl/anbs_parse.sv
module anbs_parse
	import anbs_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     load,
	input  in_item_t item,
	output bundle_t  bundle
);

	logic [7:0] held_q;
	logic [1:0] hc_q;
	logic       inside_q;
	logic       started_q;
	logic [4:0] ctype_q;
	logic [2:0] seen_q;
	logic       lead_q;

	logic [7:0]       b;
	logic             fin;
	logic [2:0]       seen_nx;
	logic             is_zero;
	logic             start_hit;
	logic [1:0]       hc_step;
	logic [2:0]       nz;
	logic             has_b;
	logic [2:0]       n;
	logic [2:0]       len;
	logic [2:0]       cnt;
	logic             squeeze;
	logic [4:0]       type_nx;
	logic [7:0]       s_arr [SRC_N];
	logic [SRC_W-1:0] src;

	function automatic logic [7:0] conf_byte(input logic [2:0] j, input logic [2:0] zn,
		input logic [7:0] v);
		return (j < zn) ? ZERO_BYTE : v;
	endfunction

	always_comb begin
		b         = item.byte_in;
		fin       = item.buffer_end;
		seen_nx   = (seen_q < SEEN_SAT) ? seen_q + 3'd1 : seen_q;
		is_zero   = (b == ZERO_BYTE);
		start_hit = (b == START_BYTE) && (hc_q >= 2'd2);
		hc_step   = (hc_q == HOLD_SAT) ? HOLD_SAT : hc_q + 2'd1;

		// Count confirmed zeros and whether the input byte itself is confirmed.
		if (start_hit) begin
			nz    = 3'd0;
			has_b = 1'b0;
		end else if (is_zero) begin
			nz    = {2'b00, (hc_q == HOLD_SAT) && inside_q}
				+ ((fin && inside_q) ? {1'b0, hc_step} : 3'd0);
			has_b = 1'b0;
		end else begin
			nz    = inside_q ? {1'b0, hc_q} : 3'd0;
			has_b = inside_q;
		end
		n   = nz + {2'b00, has_b};
		len = {2'b00, started_q} + n;

		// Sequence of confirmed bytes: held byte first, then zeros, then the input.
		for (int k = 0; k < SRC_N; k++) begin
			if (started_q) begin
				s_arr[k] = (k == 0) ? held_q : conf_byte(3'(k - 1), nz, b);
			end else begin
				s_arr[k] = conf_byte(3'(k), nz, b);
			end
		end

		type_nx = (started_q || (n == 3'd0)) ? ctype_q : (s_arr[0][4:0] & TYPE_MASK);

		squeeze = 1'b0;
		if (start_hit) begin
			cnt = (inside_q && started_q) ? 3'd1 : 3'd0;
		end else if (fin) begin
			squeeze = (len == 3'd5);
			cnt     = squeeze ? 3'(MAX_RES) : len;
		end else begin
			cnt = (len != 3'd0) ? len - 3'd1 : 3'd0;
		end
		// Drop everything from a buffer too short to hold a start code and a byte.
		if (fin && (seen_nx < SEEN_SAT)) begin
			cnt = 3'd0;
		end

		bundle.count = cnt;
		for (int i = 0; i < MAX_RES; i++) begin
			src = (squeeze && (i >= 2)) ? SRC_W'(i + 1) : SRC_W'(i);
			bundle.items[i].payload_byte = s_arr[src];
			bundle.items[i].unit_first   = (i == 0) && !lead_q;
			bundle.items[i].unit_last    = start_hit || (fin && (3'(i) + 3'd1 == cnt));
			bundle.items[i].unit_type    = type_nx;
			bundle.items[i].buffer_done  = fin && (3'(i) + 3'd1 == cnt);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q    <= ZERO_BYTE;
			hc_q      <= 2'd0;
			inside_q  <= 1'b0;
			started_q <= 1'b0;
			ctype_q   <= 5'd0;
			seen_q    <= 3'd0;
			lead_q    <= 1'b0;
		end else if (load) begin
			if (fin) begin
				held_q    <= ZERO_BYTE;
				hc_q      <= 2'd0;
				inside_q  <= 1'b0;
				started_q <= 1'b0;
				ctype_q   <= 5'd0;
				seen_q    <= 3'd0;
				lead_q    <= 1'b0;
			end else if (start_hit) begin
				held_q    <= ZERO_BYTE;
				hc_q      <= 2'd0;
				inside_q  <= 1'b1;
				started_q <= 1'b0;
				lead_q    <= 1'b0;
				seen_q    <= seen_nx;
			end else begin
				hc_q   <= is_zero ? hc_step : 2'd0;
				seen_q <= seen_nx;
				if (n != 3'd0) begin
					held_q    <= has_b ? b : ZERO_BYTE;
					started_q <= 1'b1;
					ctype_q   <= type_nx;
					lead_q    <= lead_q || (len >= 3'd2);
				end
			end
		end
	end

endmodule

>>> hw/rtl/anbs_drain.sv
module anbs_drain
	import anbs_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      load,
	input  bundle_t   bundle,
	output logic      take_ok,
	output logic      nal_valid,
	input  logic      nal_ready,
	output out_item_t nal_data
);

	out_item_t [MAX_RES-1:0] items_q;
	logic [CNT_W-1:0]        rem_q;
	logic [POS_W-1:0]        pos_q;
	logic                    pop;

	assign nal_valid = (rem_q != '0);
	assign nal_data  = items_q[pos_q];
	assign pop       = nal_valid && nal_ready;
	// Take a new bundle when no result waits or the last waiting result leaves in this cycle.
	assign take_ok   = (rem_q == '0) || ((rem_q == CNT_W'(1)) && nal_ready);

	always_ff @(posedge clk) begin
		if (load) begin
			items_q <= bundle.items;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
			pos_q <= '0;
		end else if (load) begin
			rem_q <= bundle.count;
			pos_q <= '0;
		end else if (pop) begin
			rem_q <= rem_q - CNT_W'(1);
			pos_q <= pos_q + POS_W'(1);
		end
	end

endmodule

>>> hw/rtl/annexb_nal_unit_splitter.sv
// Channel  Handshake               Payload     Moves
// stream   stream_valid/ready      in_item_t   one buffer byte with its end mark
// nal      nal_valid/ready         out_item_t  one payload byte with unit marks
//
// The parser state updates at the clock edge that takes a request on stream, and its
// results (zero to four) land in a result register.
// Results leave at one per cycle while nal_ready is high, so stream_ready stays low while
// two or more results wait, and while one waits and nal_ready is low;
// a new request is taken in the cycle the last waiting result is taken.
// arst_n clears parser state and empties the result register at once.
// A stall on nal holds the current result and, once it is the last, holds stream too.
module annexb_nal_unit_splitter
	import anbs_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      stream_valid,
	output logic      stream_ready,
	input  in_item_t  stream_data,
	output logic      nal_valid,
	input  logic      nal_ready,
	output out_item_t nal_data
);

	logic    take;
	bundle_t bundle;

	// Accept a request only when the result register can take its results.
	assign take = stream_valid && stream_ready;

	// Start-code detection, zero-run bookkeeping and result building.
	anbs_parse u_parse (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (take),
		.item   (stream_data),
		.bundle (bundle)
	);

	// Result register: hand out the results of one request in order.
	anbs_drain u_drain (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (take),
		.bundle    (bundle),
		.take_ok   (stream_ready),
		.nal_valid (nal_valid),
		.nal_ready (nal_ready),
		.nal_data  (nal_data)
	);

endmodule

>>> hw/rtl/anbs_checker.sv
`include "annexb_nal_unit_splitter_defines.svh"

module anbs_checker
	import anbs_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      stream_valid,
	input logic      stream_ready,
	input in_item_t  stream_data,
	input logic      nal_valid,
	input logic      nal_ready,
	input out_item_t nal_data
);

	logic       open_q;
	logic [4:0] type_q;

	// Track whether the last result taken left a unit open, and its type.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= 1'b0;
			type_q <= 5'd0;
		end else if (nal_valid && nal_ready) begin
			open_q <= !nal_data.unit_last;
			type_q <= nal_data.unit_type;
		end
	end

	`ANBS_ASSERT_IMP(a_first_follows_last, clk, arst_n, nal_valid,
		nal_data.unit_first == !open_q)
	`ANBS_ASSERT_IMP(a_type_steady, clk, arst_n, nal_valid && open_q,
		nal_data.unit_type == type_q)
	`ANBS_ASSERT_IMP(a_done_closes_unit, clk, arst_n, nal_valid && nal_data.buffer_done,
		nal_data.unit_last)
	`ANBS_ASSERT_NXT(a_result_holds, clk, arst_n, nal_valid && !nal_ready,
		nal_valid && $stable(nal_data))
	`ANBS_ASSERT_NXT(a_request_holds, clk, arst_n, stream_valid && !stream_ready,
		stream_valid && $stable(stream_data))

endmodule

bind annexb_nal_unit_splitter anbs_checker u_anbs_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.stream_valid (stream_valid),
	.stream_ready (stream_ready),
	.stream_data  (stream_data),
	.nal_valid    (nal_valid),
	.nal_ready    (nal_ready),
	.nal_data     (nal_data)
);
